// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HLM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define HLM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hlm_pkg.sv
package hlm_pkg;

  localparam int unsigned LOCKS_DEF = 256;
  localparam int unsigned PROCS_DEF = 8;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned LOCK_W = 8;
  localparam int unsigned PROC_W = 3;
  localparam int unsigned OUT_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_OTHER   = 2'd2
  } cmd_e;

  typedef enum logic [OUT_W-1:0] {
    OUT_GRANTED = 3'd0,
    OUT_SLEEPS  = 3'd1,
    OUT_FREED   = 3'd2,
    OUT_HANDED  = 3'd3,
    OUT_INVALID = 3'd4,
    OUT_FULL    = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SLOT
  } state_e;

endpackage

// File: design/hardware_lock_manager_fifo_wait.sv
// Flow: a request is taken in IDLE, looked up in the lock-table RAM in LOOKUP, and its result
// goes to the output register; a handoff to a waiter adds the dependent wait-slot RAM read
// in SLOT. The result load waits while the output is stalled; one request in flight at a time.
// Output register lets a new request in while the previous result waits.
// Reset: per-lock valid flops clear at once, so all locks read free with empty queues;
// no clearing pass, wait slots are only read after being written.
module hardware_lock_manager_fifo_wait #(
  parameter int unsigned LOCKS = hlm_pkg::LOCKS_DEF,
  parameter int unsigned PROCS = hlm_pkg::PROCS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hlm_pkg::CMD_W-1:0]  command_i,
  input  logic [hlm_pkg::LOCK_W-1:0] lock_id_i,
  input  logic [hlm_pkg::PROC_W-1:0] proc_id_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [hlm_pkg::OUT_W-1:0]  outcome_o,
  output logic                      sleep_valid_o,
  output logic                      wake_valid_o,
  output logic [hlm_pkg::PROC_W-1:0] wake_proc_o
);

  localparam int unsigned LkAw   = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int unsigned HW     = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CW     = $clog2(PROCS + 1);
  localparam int unsigned EntW   = 1 + HW + CW;
  localparam int unsigned SlDep  = LOCKS * PROCS;
  localparam int unsigned SlAw   = (SlDep > 1) ? $clog2(SlDep) : 1;
  localparam int unsigned PW     = hlm_pkg::PROC_W;

  hlm_pkg::state_e state_q, state_d;

  logic [hlm_pkg::CMD_W-1:0]  cmd_q;
  logic [hlm_pkg::LOCK_W-1:0] lock_q;
  logic [PW-1:0]              proc_q;
  logic [LOCKS-1:0]           vld_q;

  logic                       out_valid_q, out_valid_d;
  logic [hlm_pkg::OUT_W-1:0]  outcome_q, outcome_d;
  logic                       sleep_q, sleep_d;
  logic                       wake_q, wake_d;
  logic [PW-1:0]              wake_proc_q, wake_proc_d;
  logic                       out_load;

  logic                       in_fire;
  logic [LkAw-1:0]            lk_idx;
  logic                       lk_ok, req_ok;
  logic                       is_acq, is_rel;
  logic [EntW-1:0]            ent_rdata, ent;
  logic                       held;
  logic [HW-1:0]              head, head_nx;
  logic [CW-1:0]              count;
  logic [CW:0]                pos_sum, pos_wrap;
  logic [HW-1:0]              pos;
  logic [SlAw-1:0]            slot_base;
  logic                       out_free;

  logic                       st_we;
  logic [EntW-1:0]            st_wdata;
  logic                       sl_we, sl_re;
  logic [SlAw-1:0]            sl_waddr, sl_raddr;
  logic [PW-1:0]              sl_rdata;

  assign in_ready_o = (state_q == hlm_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  hlm_ram #(
    .WIDTH (EntW),
    .DEPTH (LOCKS)
  ) u_lock_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (lk_idx),
    .wdata_i (st_wdata),
    .re_i    (in_fire),
    .raddr_i (lock_id_i[LkAw-1:0]),
    .rdata_o (ent_rdata)
  );

  hlm_ram #(
    .WIDTH (PW),
    .DEPTH (SlDep)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (proc_q),
    .re_i    (sl_re),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  // decode of the request held for the lookup
  assign lk_idx = lock_q[LkAw-1:0];
  assign lk_ok  = ({1'b0, lock_q} < (hlm_pkg::LOCK_W + 1)'(LOCKS));
  assign is_acq = (cmd_q == hlm_pkg::CMD_ACQUIRE);
  assign is_rel = (cmd_q == hlm_pkg::CMD_RELEASE);
  assign req_ok = lk_ok && (is_acq || is_rel);

  // a lock never written since reset reads as free with an empty queue
  assign ent   = vld_q[lk_idx] ? ent_rdata : '0;
  assign held  = ent[EntW-1];
  assign head  = ent[CW +: HW];
  assign count = ent[CW-1:0];

  assign head_nx  = (head == HW'(PROCS - 1)) ? '0 : head + 1'b1;
  assign pos_sum  = (CW + 1)'(head) + (CW + 1)'(count);
  assign pos_wrap = (pos_sum >= (CW + 1)'(PROCS)) ? pos_sum - (CW + 1)'(PROCS) : pos_sum;
  assign pos      = pos_wrap[HW-1:0];

  assign slot_base = SlAw'(lk_idx) * SlAw'(PROCS);
  assign sl_waddr  = slot_base + SlAw'(pos);
  assign sl_raddr  = slot_base + SlAw'(head);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    st_we       = 1'b0;
    st_wdata    = ent;
    sl_we       = 1'b0;
    sl_re       = 1'b0;
    out_load    = 1'b0;
    outcome_d   = hlm_pkg::OUT_INVALID;
    sleep_d     = 1'b0;
    wake_d      = 1'b0;
    wake_proc_d = '0;

    unique case (state_q)
      hlm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = hlm_pkg::ST_LOOKUP;
        end
      end

      hlm_pkg::ST_LOOKUP: begin
        if (req_ok && is_rel && (count != '0)) begin
          // handoff: pop the oldest waiter, fetch its id next cycle
          sl_re    = 1'b1;
          st_we    = 1'b1;
          st_wdata = {1'b1, head_nx, count - 1'b1};
          state_d  = hlm_pkg::ST_SLOT;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = hlm_pkg::ST_IDLE;
          if (!req_ok) begin
            outcome_d = hlm_pkg::OUT_INVALID;
          end else if (is_acq && !held) begin
            outcome_d = hlm_pkg::OUT_GRANTED;
            st_we     = 1'b1;
            st_wdata  = {1'b1, head, count};
          end else if (is_acq && (count == CW'(PROCS))) begin
            outcome_d = hlm_pkg::OUT_FULL;
          end else if (is_acq) begin
            outcome_d = hlm_pkg::OUT_SLEEPS;
            sleep_d   = 1'b1;
            sl_we     = 1'b1;
            st_we     = 1'b1;
            st_wdata  = {1'b1, head, count + 1'b1};
          end else begin
            outcome_d = hlm_pkg::OUT_FREED;
            st_we     = 1'b1;
            st_wdata  = {1'b0, head, count};
          end
        end
      end

      hlm_pkg::ST_SLOT: begin
        if (out_free) begin
          out_load    = 1'b1;
          outcome_d   = hlm_pkg::OUT_HANDED;
          wake_d      = 1'b1;
          wake_proc_d = sl_rdata;
          state_d     = hlm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = hlm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hlm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (st_we) begin
        vld_q[lk_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= command_i;
      lock_q <= lock_id_i;
      proc_q <= proc_id_i;
    end
    if (out_load) begin
      outcome_q   <= outcome_d;
      sleep_q     <= sleep_d;
      wake_q      <= wake_d;
      wake_proc_q <= wake_proc_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign sleep_valid_o = sleep_q;
  assign wake_valid_o  = wake_q;
  assign wake_proc_o   = wake_proc_q;

endmodule

// File: design/hlm_ram.sv
module hlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/hlm_checker.sv
`include "assert_macros.svh"

module hlm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [hlm_pkg::CMD_W-1:0]  command_i,
  input logic [hlm_pkg::LOCK_W-1:0] lock_id_i,
  input logic [hlm_pkg::PROC_W-1:0] proc_id_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [hlm_pkg::OUT_W-1:0]  outcome_o,
  input logic                      sleep_valid_o,
  input logic                      wake_valid_o,
  input logic [hlm_pkg::PROC_W-1:0] wake_proc_o
);

  // held result must not change while stalled
  `HLM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(outcome_o) && $stable(wake_proc_o), "result changed while stalled")

  // one request in flight: no accept on the cycle after an accept
  `HLM_ASSERT_NXT(a_one_inflight, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

  `HLM_ASSERT_IMP(a_sleep_code, out_valid_o, sleep_valid_o == (outcome_o == hlm_pkg::OUT_SLEEPS), "sleep flag disagrees with outcome")

  `HLM_ASSERT_IMP(a_wake_code, out_valid_o, wake_valid_o == (outcome_o == hlm_pkg::OUT_HANDED), "wake flag disagrees with outcome")

  `HLM_ASSERT_IMP(a_wake_zero, out_valid_o && !wake_valid_o, wake_proc_o == '0, "wake id set without wake")

endmodule

bind hardware_lock_manager_fifo_wait hlm_checker u_hlm_checker (.*);
